// ----- hw/rtl/rgb_to_hsv_8bit_unit_defines.svh -----
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_8BIT_UNIT_DEFINES_SVH
`define RGB_TO_HSV_8BIT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTHSV_ASSERT_IMPLY(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("rthsv: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RTHSV_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("rthsv: next-cycle check failed");

`endif

// ----- hw/rtl/rthsv_pkg.sv -----
// Types and constants of the RGB to HSV converter.
`default_nettype none
package rthsv_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned NUM_CELLS = 8;

    localparam logic [CHAN_W-1:0] HUE_STEP      = 8'd43;
    localparam logic [CHAN_W-1:0] HUE_OFS_RED   = 8'd0;
    localparam logic [CHAN_W-1:0] HUE_OFS_GREEN = 8'd85;
    localparam logic [CHAN_W-1:0] HUE_OFS_BLUE  = 8'd171;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    // One restoring divider lane: partial remainder, dividend bits still to
    // shift in (low end filling with quotient bits) and the divisor.
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] work;
        logic [CHAN_W-1:0] div;
    } lane_t;

    typedef struct packed {
        lane_t             sat;
        lane_t             hue;
        logic [CHAN_W-1:0] offset;
        logic              neg;
        logic              flat;
        logic [CHAN_W-1:0] brightness;
    } cell_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rthsv_front.sv -----
// Input stage: max/min, hue sector and dividends for the divider chain.
`default_nettype none
module rthsv_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rthsv_pkg::pixel_t   in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rthsv_pkg::cell_word_t    out_word
);

    logic                  valid_reg;
    rthsv_pkg::cell_word_t data_reg;
    rthsv_pkg::cell_word_t data_next;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  spread;
    logic [8:0]  diff;
    logic [8:0]  mag_full;
    logic [7:0]  mag;
    logic [15:0] n_hue;
    logic [15:0] n_sat;

    always_comb begin
        hi = (in_word.red > in_word.green) ? in_word.red : in_word.green;
        hi = (hi > in_word.blue) ? hi : in_word.blue;
        lo = (in_word.red < in_word.green) ? in_word.red : in_word.green;
        lo = (lo < in_word.blue) ? lo : in_word.blue;
        spread = hi - lo;

        // Sector: first channel holding the max, in red, green, blue order.
        if (hi == in_word.red) begin
            data_next.offset = rthsv_pkg::HUE_OFS_RED;
            diff = {1'b0, in_word.green} - {1'b0, in_word.blue};
        end else if (hi == in_word.green) begin
            data_next.offset = rthsv_pkg::HUE_OFS_GREEN;
            diff = {1'b0, in_word.blue} - {1'b0, in_word.red};
        end else begin
            data_next.offset = rthsv_pkg::HUE_OFS_BLUE;
            diff = {1'b0, in_word.red} - {1'b0, in_word.green};
        end
        mag_full = diff[8] ? (9'd0 - diff) : diff;
        mag      = mag_full[7:0];

        n_hue = 16'(mag) * 16'(rthsv_pkg::HUE_STEP);
        n_sat = {spread, 8'd0} - {8'd0, spread};

        // Quotients fit 8 bits, so the top dividend byte is already below the divisor.
        data_next.hue.rem    = n_hue[15:8];
        data_next.hue.work   = n_hue[7:0];
        data_next.hue.div    = spread;
        data_next.sat.rem    = n_sat[15:8];
        data_next.sat.work   = n_sat[7:0];
        data_next.sat.div    = hi;
        data_next.neg        = diff[8];
        data_next.flat       = (spread == 8'd0);
        data_next.brightness = hi;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/rthsv_div_cell.sv -----
// One divider cell: a restoring step for the saturation and hue lanes.
`default_nettype none
`include "rgb_to_hsv_8bit_unit_defines.svh"
module rthsv_div_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rthsv_pkg::cell_word_t in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rthsv_pkg::cell_word_t      out_word
);

    logic                  valid_reg;
    rthsv_pkg::cell_word_t data_reg;
    rthsv_pkg::cell_word_t data_next;

    function automatic rthsv_pkg::lane_t div_step(input rthsv_pkg::lane_t l);
        rthsv_pkg::lane_t res;
        logic [8:0]       trial;
        logic             qbit;
        trial = {l.rem, l.work[7]};
        qbit  = (trial >= {1'b0, l.div});
        if (qbit) begin
            trial = trial - {1'b0, l.div};
        end
        res.rem  = trial[7:0];
        res.work = {l.work[6:0], qbit};
        res.div  = l.div;
        return res;
    endfunction

    always_comb begin
        data_next     = in_word;
        data_next.sat = div_step(in_word.sat);
        data_next.hue = div_step(in_word.hue);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    `RTHSV_ASSERT_NEXT(a_stall_hold, aclk, aresetn, valid_reg && !out_ready,
        valid_reg && $stable(data_reg))
    `RTHSV_ASSERT_IMPLY(a_sat_rem_bound, aclk, aresetn,
        valid_reg && data_reg.sat.div != 8'd0, data_reg.sat.rem < data_reg.sat.div)
    `RTHSV_ASSERT_IMPLY(a_hue_rem_bound, aclk, aresetn,
        valid_reg && data_reg.hue.div != 8'd0, data_reg.hue.rem < data_reg.hue.div)

endmodule
`default_nettype wire

// ----- hw/rtl/rthsv_back.sv -----
// Output stage: sign and offset of the hue, flat-pixel cases, result register.
`default_nettype none
module rthsv_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rthsv_pkg::cell_word_t in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rthsv_pkg::hsv_t            out_word
);

    logic            valid_reg;
    rthsv_pkg::hsv_t data_reg;
    rthsv_pkg::hsv_t data_next;
    logic [7:0]      q_signed;

    always_comb begin
        // Negate the magnitude quotient: truncation toward zero.
        q_signed = in_word.neg ? (8'd0 - in_word.hue.work) : in_word.hue.work;
        data_next.brightness = in_word.brightness;
        if (in_word.flat) begin
            data_next.saturation = 8'd0;
            data_next.hue        = 8'd0;
        end else begin
            data_next.saturation = in_word.sat.work;
            data_next.hue        = in_word.offset + q_signed;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = data_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_8bit_unit.sv -----
// Top level of the RGB to HSV converter: front stage, divider cells, output stage.
`default_nettype none
`include "rgb_to_hsv_8bit_unit_defines.svh"
// Converts one 8-bit RGB pixel per clock into 8-bit hue, saturation and value
// while the chain is not held up by a stalled output. Ten registered stages:
// one front stage, eight divider cells (one quotient bit each for the
// saturation and hue divisions) and one output register. Every stage holds
// its own valid bit and passes its word on whenever the next stage is empty
// or moving, so bubbles close up while the output is stalled, and s_ready
// falls only once every stage is full and the output is stalled.
module rgb_to_hsv_8bit_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rthsv_pkg::pixel_t s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rthsv_pkg::hsv_t        m_word
);

    logic                  chain_valid [rthsv_pkg::NUM_CELLS+1];
    logic                  chain_ready [rthsv_pkg::NUM_CELLS+1];
    rthsv_pkg::cell_word_t chain_word  [rthsv_pkg::NUM_CELLS+1];

    rthsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_word),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    for (genvar i = 0; i < rthsv_pkg::NUM_CELLS; i++) begin : g_cell
        rthsv_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    rthsv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[rthsv_pkg::NUM_CELLS]),
        .in_ready  (chain_ready[rthsv_pkg::NUM_CELLS]),
        .in_word   (chain_word[rthsv_pkg::NUM_CELLS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

    `RTHSV_ASSERT_IMPLY(a_grey_hue_zero, aclk, aresetn,
        m_valid && m_word.saturation == 8'd0, m_word.hue == 8'd0)
    `RTHSV_ASSERT_IMPLY(a_sat_needs_value, aclk, aresetn,
        m_valid && m_word.saturation != 8'd0, m_word.brightness != 8'd0)
    `RTHSV_ASSERT_IMPLY(a_empty_out_ready, aclk, aresetn, !m_valid, s_ready)

endmodule
`default_nettype wire

// ----- sim/rgb_to_hsv_8bit_unit_tb.sv -----
// Self-checking testbench for the RGB to HSV converter.
`default_nettype none
module rgb_to_hsv_8bit_unit_tb;

    localparam int FULL_SCALE  = 255;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 14;
    localparam int PRINT_LIMIT = 20;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    rthsv_pkg::pixel_t s_word = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rthsv_pkg::hsv_t   m_word;

    rthsv_pkg::hsv_t hsv_expected[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   pixels_sent = 0;
    int   results_checked = 0;
    int   input_stalls = 0;
    int   fail_count = 0;

    rgb_to_hsv_8bit_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("rgb_to_hsv_8bit_unit verification failed");
        $finish;
    end

    function automatic rthsv_pkg::pixel_t make_rgb(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
        rthsv_pkg::pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // Hue sector goes to the first channel holding the maximum, red first.
    function automatic rthsv_pkg::hsv_t convert_pixel(rthsv_pkg::pixel_t px);
        int              r, g, b, top, bottom, spread, sat, hue;
        rthsv_pkg::hsv_t res;
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        top = (r > g) ? r : g;
        top = (top > b) ? top : b;
        bottom = (r < g) ? r : g;
        bottom = (bottom < b) ? bottom : b;
        spread = top - bottom;
        sat = 0;
        hue = 0;
        if (top != 0) begin
            sat = (FULL_SCALE * spread) / top;
            if (sat != 0) begin
                // int division truncates toward zero, as the block must
                if (top == r)
                    hue = int'(rthsv_pkg::HUE_OFS_RED)
                        + (int'(rthsv_pkg::HUE_STEP) * (g - b)) / spread;
                else if (top == g)
                    hue = int'(rthsv_pkg::HUE_OFS_GREEN)
                        + (int'(rthsv_pkg::HUE_STEP) * (b - r)) / spread;
                else
                    hue = int'(rthsv_pkg::HUE_OFS_BLUE)
                        + (int'(rthsv_pkg::HUE_STEP) * (r - g)) / spread;
            end
        end
        res.hue        = hue[7:0];
        res.saturation = sat[7:0];
        res.brightness = top[7:0];
        return res;
    endfunction

    // Bias toward greys, ties, near-blacks, full channels and near-greys, where the hue math is touchy.
    function automatic rthsv_pkg::pixel_t pick_pixel();
        rthsv_pkg::pixel_t px;
        logic [7:0]        base;
        base = 8'($urandom_range(255));
        px = make_rgb(8'($urandom), 8'($urandom), 8'($urandom));
        case ($urandom_range(9))
            5: px = make_rgb(base, base, base);
            6: begin
                case ($urandom_range(2))
                    0: px.green = px.red;
                    1: px.blue = px.green;
                    default: px.blue = px.red;
                endcase
            end
            7: px = make_rgb(8'($urandom_range(3)), 8'($urandom_range(3)),
                             8'($urandom_range(3)));
            8: begin
                case ($urandom_range(2))
                    0: px.red = 8'hff;
                    1: px.green = 8'hff;
                    default: px.blue = 8'hff;
                endcase
            end
            9: px = make_rgb(base, base ^ 8'($urandom_range(3)), base ^ 8'($urandom_range(3)));
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < PRINT_LIMIT)
            $display("MISMATCH %s", msg);
        fail_count++;
    endtask

    // Hold valid across back-to-back words; drop it only for idle cycles.
    task automatic send_pixel(rthsv_pkg::pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= px;
        do @(posedge aclk); while (!s_ready);
        hsv_expected.push_back(convert_pixel(px));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic test_special_pixels();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(make_rgb(8'd0,   8'd0,   8'd0));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd128, 8'd128, 8'd128));
        send_pixel(make_rgb(8'd1,   8'd1,   8'd1));
        send_pixel(make_rgb(8'd255, 8'd0,   8'd0));
        send_pixel(make_rgb(8'd0,   8'd255, 8'd0));
        send_pixel(make_rgb(8'd0,   8'd0,   8'd255));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd0));
        send_pixel(make_rgb(8'd0,   8'd255, 8'd255));
        send_pixel(make_rgb(8'd255, 8'd0,   8'd255));
        send_pixel(make_rgb(8'd255, 8'd0,   8'd128));
        send_pixel(make_rgb(8'd255, 8'd0,   8'd1));
        send_pixel(make_rgb(8'd1,   8'd0,   8'd0));
        send_pixel(make_rgb(8'd0,   8'd0,   8'd1));
        send_pixel(make_rgb(8'd255, 8'd254, 8'd254));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd254));
        send_pixel(make_rgb(8'd128, 8'd255, 8'd0));
        send_pixel(make_rgb(8'd0,   8'd255, 8'd1));
        send_pixel(make_rgb(8'd128, 8'd0,   8'd255));
        send_pixel(make_rgb(8'd1,   8'd0,   8'd255));
        send_pixel(make_rgb(8'd255, 8'd128, 8'd0));
        send_pixel(make_rgb(8'd1,   8'd2,   8'd3));
        send_pixel(make_rgb(8'd3,   8'd2,   8'd1));
        wait_drained();
    endtask

    task automatic test_streaming(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_pixel(pick_pixel());
        wait_drained();
    endtask

    // Freeze the output so the pipeline fills and pushes back on the input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (40) send_pixel(pick_pixel());
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
    end

    always @(posedge aclk) begin
        rthsv_pkg::hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = hsv_expected.pop_front();
                if (m_word.hue !== want.hue)
                    report_mismatch($sformatf("hue: got %0d, expected %0d",
                                              m_word.hue, want.hue));
                if (m_word.saturation !== want.saturation)
                    report_mismatch($sformatf("saturation: got %0d, expected %0d",
                                              m_word.saturation, want.saturation));
                if (m_word.brightness !== want.brightness)
                    report_mismatch($sformatf("brightness: got %0d, expected %0d",
                                              m_word.brightness, want.brightness));
                results_checked++;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_pixels();
        test_streaming(130, 0, 0);
        test_streaming(130, 54, 0);
        test_streaming(130, 0, 54);
        test_streaming(130, 23, 23);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hsv_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", hsv_expected.size()));
        $display("Converted %0d pixels, checked %0d results, saw %0d input stall cycles.",
                 pixels_sent, results_checked, input_stalls);
        $display("Covered black, grey, sector ties, wrapping hue and full-pipeline stalls.");
        if (fail_count == 0)
            $display("rgb_to_hsv_8bit_unit verification clean");
        else
            $display("rgb_to_hsv_8bit_unit verification failed");
        $finish;
    end

endmodule
`default_nettype wire
